>>> hdl/sbpr_pkg.sv
// Shared types, codes and reply encoding for the servo bus packet receiver.
package sbpr_pkg;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_ABANDON = 3'd1,
        EV_BAD_SUM = 3'd2,
        EV_OTHER   = 3'd3,
        EV_OWN     = 3'd4,
        EV_PARAM   = 3'd5,
        EV_REPLY   = 3'd6
    } t_event;

    localparam logic [7:0] PREAMBLE      = 8'hff;
    localparam logic [7:0] ID_LIMIT      = 8'd254;
    localparam logic [7:0] LEN_LIMIT     = 8'd100;
    localparam logic [7:0] INSTR_LIMIT   = 8'h07;
    localparam logic [7:0] INSTR_SYNC_WR = 8'h83;
    localparam logic [7:0] INSTR_PING    = 8'h01;
    localparam logic [7:0] DEVICE_ID_RST = 8'd10;
    localparam logic [2:0] REPLY_LEN     = 3'd6;
    localparam logic [7:0] REPLY_LEN_FLD = 8'd2;
    localparam logic [7:0] REPLY_ERROR   = 8'd0;

    // Byte k of the status reply FF FF id 02 00 ~(id+2).
    function automatic logic [7:0] reply_byte(input logic [2:0] k, input logic [7:0] id);
        logic [7:0] b;
        case (k)
            3'd0:    b = PREAMBLE;
            3'd1:    b = PREAMBLE;
            3'd2:    b = id;
            3'd3:    b = REPLY_LEN_FLD;
            3'd4:    b = REPLY_ERROR;
            3'd5:    b = ~(id + REPLY_LEN_FLD);
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/servo_bus_packet_receiver.sv
// Servo bus packet receiver: frame parser with registered event output and ping reply.
// A received byte's first result appears in the output register in the cycle after
// the byte is accepted. Throughput: one byte per cycle whenever the result side keeps up.
// A good ping to this device yields seven results; the reply counter holds off new bytes
// while the six reply bytes are presented.
// Reset (synchronous, active low) returns the parser to waiting for the first preamble,
// empties the output register and sets the device id to 10.
module servo_bus_packet_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Received byte channel.
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    // Result channel.
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [2:0] o_event_res,
    output logic [7:0] o_instruction,
    output logic [6:0] o_param_index,
    output logic [7:0] o_param_byte,
    output logic [7:0] o_tx_byte,
    output logic       o_last,
    // Configuration write channel for the device id.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_PRE1, ST_PRE2, ST_ID, ST_LEN, ST_INSTR, ST_PARAM, ST_CSUM
    } t_state;

    // Parser state.
    t_state     r_state,      n_state;
    logic [7:0] r_frame_id,   n_frame_id;
    logic [6:0] r_frame_len,  n_frame_len;
    logic [7:0] r_frame_ins,  n_frame_ins;
    logic [7:0] r_sum,        n_sum;
    logic [6:0] r_seen,       n_seen;
    logic [7:0] r_device_id;
    // Number of reply bytes still to be presented.
    logic [2:0] r_reply_cnt,  n_reply_cnt;

    // Output register.
    logic       r_out_valid,  n_out_valid;
    logic [2:0] r_event,      n_event;
    logic [7:0] r_instr,      n_instr;
    logic [6:0] r_pidx,       n_pidx;
    logic [7:0] r_pbyte,      n_pbyte;
    logic [7:0] r_txb,        n_txb;
    logic       r_last,       n_last;

    logic       out_free;
    logic       rx_take;
    logic [6:0] param_count;
    logic [6:0] seen_inc;
    logic       start_reply;
    t_state     p_state;
    logic [2:0] p_event;
    logic       p_last;

    // The output register may be reloaded when empty or when its request is taken now.
    assign out_free    = !r_out_valid || !i_res_stall;
    assign o_rx_stall  = (r_reply_cnt != 3'd0) || !out_free;
    assign rx_take     = i_rx_valid && !o_rx_stall;
    assign o_cfg_ready = 1'b1;

    // Length minus two, with short lengths meaning no parameters.
    assign param_count = (r_frame_len < 7'd2) ? 7'd0 : r_frame_len - 7'd2;
    assign seen_inc    = r_seen + 7'd1;

    // Frame parser: one state transition per received byte.
    always_comb begin
        n_frame_id  = r_frame_id;
        n_frame_len = r_frame_len;
        n_frame_ins = r_frame_ins;
        n_sum       = r_sum;
        n_seen      = r_seen;
        p_state     = r_state;
        p_event     = sbpr_pkg::EV_NONE;
        p_last      = 1'b1;
        start_reply = 1'b0;
        case (r_state)
            ST_PRE1: begin
                if (i_rx_byte == sbpr_pkg::PREAMBLE) p_state = ST_PRE2;
            end
            ST_PRE2: begin
                if (i_rx_byte == sbpr_pkg::PREAMBLE) begin
                    p_state = ST_ID;
                end else begin
                    p_state = ST_PRE1;
                    p_event = sbpr_pkg::EV_ABANDON;
                end
            end
            ST_ID: begin
                if (i_rx_byte < sbpr_pkg::ID_LIMIT) begin
                    n_frame_id = i_rx_byte;
                    n_sum      = i_rx_byte;
                    p_state    = ST_LEN;
                end else begin
                    p_state = ST_PRE1;
                    p_event = sbpr_pkg::EV_ABANDON;
                end
            end
            ST_LEN: begin
                if (i_rx_byte < sbpr_pkg::LEN_LIMIT) begin
                    n_frame_len = i_rx_byte[6:0];
                    n_sum       = r_sum + i_rx_byte;
                    p_state     = ST_INSTR;
                end else begin
                    p_state = ST_PRE1;
                    p_event = sbpr_pkg::EV_ABANDON;
                end
            end
            ST_INSTR: begin
                if (i_rx_byte < sbpr_pkg::INSTR_LIMIT ||
                    i_rx_byte == sbpr_pkg::INSTR_SYNC_WR) begin
                    n_frame_ins = i_rx_byte;
                    n_sum       = r_sum + i_rx_byte;
                    n_seen      = 7'd0;
                    p_state     = (param_count == 7'd0) ? ST_CSUM : ST_PARAM;
                end else begin
                    p_state = ST_PRE1;
                    p_event = sbpr_pkg::EV_ABANDON;
                end
            end
            ST_PARAM: begin
                n_sum   = r_sum + i_rx_byte;
                n_seen  = seen_inc;
                p_event = sbpr_pkg::EV_PARAM;
                if (seen_inc >= param_count) p_state = ST_CSUM;
            end
            ST_CSUM: begin
                p_state = ST_PRE1;
                if (i_rx_byte != ~r_sum) begin
                    p_event = sbpr_pkg::EV_BAD_SUM;
                end else if (r_frame_id != r_device_id) begin
                    p_event = sbpr_pkg::EV_OTHER;
                end else begin
                    p_event = sbpr_pkg::EV_OWN;
                    if (r_frame_ins == sbpr_pkg::INSTR_PING) begin
                        start_reply = 1'b1;
                        p_last      = 1'b0;
                    end
                end
            end
            default: begin
                p_state = ST_PRE1;
            end
        endcase
    end

    // Output register loading: pending reply bytes go first, then parsed bytes.
    always_comb begin
        n_state     = r_state;
        n_reply_cnt = r_reply_cnt;
        n_out_valid = r_out_valid;
        n_event     = r_event;
        n_instr     = r_instr;
        n_pidx      = r_pidx;
        n_pbyte     = r_pbyte;
        n_txb       = r_txb;
        n_last      = r_last;
        if (out_free) begin
            if (r_reply_cnt != 3'd0) begin
                n_out_valid = 1'b1;
                n_event     = sbpr_pkg::EV_REPLY;
                n_pidx      = 7'd0;
                n_pbyte     = 8'd0;
                n_txb       = sbpr_pkg::reply_byte(sbpr_pkg::REPLY_LEN - r_reply_cnt,
                                                   r_device_id);
                n_last      = (r_reply_cnt == 3'd1);
                n_reply_cnt = r_reply_cnt - 3'd1;
            end else if (rx_take) begin
                n_state     = p_state;
                n_out_valid = 1'b1;
                n_event     = p_event;
                n_instr     = n_frame_ins;
                n_pidx      = (p_event == sbpr_pkg::EV_PARAM) ? r_seen : 7'd0;
                n_pbyte     = (p_event == sbpr_pkg::EV_PARAM) ? i_rx_byte : 8'd0;
                n_txb       = 8'd0;
                n_last      = p_last;
                n_reply_cnt = start_reply ? sbpr_pkg::REPLY_LEN : 3'd0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_PRE1;
            r_frame_id  <= 8'd0;
            r_frame_len <= 7'd0;
            r_frame_ins <= 8'd0;
            r_sum       <= 8'd0;
            r_seen      <= 7'd0;
            r_device_id <= sbpr_pkg::DEVICE_ID_RST;
            r_reply_cnt <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_reply_cnt <= n_reply_cnt;
            r_out_valid <= n_out_valid;
            if (rx_take) begin
                r_frame_id  <= n_frame_id;
                r_frame_len <= n_frame_len;
                r_frame_ins <= n_frame_ins;
                r_sum       <= n_sum;
                r_seen      <= n_seen;
            end
            if (i_cfg_valid && o_cfg_ready) r_device_id <= i_cfg_data;
        end
    end

    // Result payload carries no reset.
    always_ff @(posedge i_clk) begin
        r_event <= n_event;
        r_instr <= n_instr;
        r_pidx  <= n_pidx;
        r_pbyte <= n_pbyte;
        r_txb   <= n_txb;
        r_last  <= n_last;
    end

    assign o_res_valid   = r_out_valid;
    assign o_event_res   = r_event;
    assign o_instruction = r_instr;
    assign o_param_index = r_pidx;
    assign o_param_byte  = r_pbyte;
    assign o_tx_byte     = r_txb;
    assign o_last        = r_last;

endmodule

>>> hdl/sbpr_checker.sv
// Port-level checks for the servo bus packet receiver, bound to the top level.
module sbpr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_rx_stall,
    input logic       o_res_valid,
    input logic       i_res_stall,
    input logic [2:0] o_event_res,
    input logic [6:0] o_param_index,
    input logic [7:0] o_param_byte,
    input logic [7:0] o_tx_byte,
    input logic       o_last
);

    // A stalled result request holds its event, transmit byte and last flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_event_res) &&
            $stable(o_tx_byte) && $stable(o_last))
        else $error("stalled result changed");

    // Once a ping acknowledgement is taken, the input is held off while the first reply byte is presented.
    a_reply_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_stall && o_event_res == sbpr_pkg::EV_OWN && !o_last
            |=> o_rx_stall)
        else $error("input not held off during reply");

    // Parameter fields are zero on every other event.
    a_param_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_event_res != sbpr_pkg::EV_PARAM
            |-> o_param_byte == 8'd0 && o_param_index == 7'd0)
        else $error("parameter fields set outside a parameter event");

    // Only own-packet and reply results may be non-final.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_event_res != sbpr_pkg::EV_OWN &&
            o_event_res != sbpr_pkg::EV_REPLY |-> o_last)
        else $error("single result not marked last");

    // The transmit byte is zero except on reply results.
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_event_res != sbpr_pkg::EV_REPLY |-> o_tx_byte == 8'd0)
        else $error("transmit byte set outside a reply");

endmodule

bind servo_bus_packet_receiver sbpr_checker u_sbpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_rx_stall    (o_rx_stall),
    .o_res_valid   (o_res_valid),
    .i_res_stall   (i_res_stall),
    .o_event_res   (o_event_res),
    .o_param_index (o_param_index),
    .o_param_byte  (o_param_byte),
    .o_tx_byte     (o_tx_byte),
    .o_last        (o_last)
);
